@@ hdl/json_string_unescape_utf8_assert.svh @@
// Assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH

`define JSU_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define JSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/jsu_pkg.sv @@
`timescale 1ns / 1ps
package jsu_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;

  localparam logic [5:0] SURR_HI_TAG = 6'b110110;
  localparam logic [5:0] SURR_LO_TAG = 6'b110111;
  localparam logic [20:0] SUPP_BASE  = 21'h10000;

  typedef enum logic [5:0] {
    M_PLAIN    = 6'b000001,
    M_ESC      = 6'b000010,
    M_HEX      = 6'b000100,
    M_HIGH     = 6'b001000,
    M_HIGH_ESC = 6'b010000,
    M_LOW_HEX  = 6'b100000
  } mode_t;

  typedef enum logic [1:0] {
    TERM_NONE = 2'd0,
    TERM_DONE = 2'd1,
    TERM_ERR  = 2'd2
  } term_t;

  typedef struct packed {
    logic        has_a;
    logic [9:0]  a_lo;
    logic [2:0]  b_len;
    logic [20:0] b_cp;
    term_t       term;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic logic [7:0] esc_byte(input logic [7:0] e);
    logic [7:0] r;
    unique case (e)
      CH_N:    r = 8'h0A;
      CH_T:    r = 8'h09;
      CH_R:    r = 8'h0D;
      CH_B:    r = 8'h08;
      CH_F:    r = 8'h0C;
      default: r = e;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] utf8_len(input logic [20:0] cp);
    logic [2:0] r;
    if (cp < 21'h80) begin
      r = 3'd1;
    end else if (cp < 21'h800) begin
      r = 3'd2;
    end else if (cp < 21'h10000) begin
      r = 3'd3;
    end else begin
      r = 3'd4;
    end
    return r;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] len,
                                           input logic [1:0] idx);
    logic [7:0] r;
    r = cp[7:0];
    case (len)
      3'd2: begin
        r = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
      end
      3'd3: begin
        case (idx)
          2'd0:    r = {4'b1110, cp[15:12]};
          2'd1:    r = {2'b10, cp[11:6]};
          default: r = {2'b10, cp[5:0]};
        endcase
      end
      3'd4: begin
        case (idx)
          2'd0:    r = {5'b11110, cp[20:18]};
          2'd1:    r = {2'b10, cp[17:12]};
          2'd2:    r = {2'b10, cp[11:6]};
          default: r = {2'b10, cp[5:0]};
        endcase
      end
      default: r = cp[7:0];
    endcase
    return r;
  endfunction

endpackage

@@ hdl/json_string_unescape_utf8.sv @@
`timescale 1ns / 1ps
// JSON string body unescaper with UTF-8 output. Feed the bytes after the opening
// quote, one per item; every result item carries either a decoded byte, the done
// mark of the closing quote, or an error, and out_last flags the final result of
// each input byte (bytes that only advance an escape give no result). An input is
// accepted every cycle while the result queue (QUEUE_DEPTH entries) has room;
// results leave one per cycle while out_ready is high, so an input that yields n
// results gives n output items (n is 1 for plain text, up to 7 around surrogate
// escapes); each passes the result queue, then the output register, to the output.
`include "json_string_unescape_utf8_assert.svh"
module json_string_unescape_utf8 #(
  parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_buffer_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_done_res,
  output logic       out_error,
  output logic       out_last
);

  jsu_pkg::q_stat_t q_stat;
  jsu_pkg::entry_t  q_data, q_head;
  logic             q_push, q_pop;

  jsu_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .in_buffer_end (in_buffer_end),
    .q_stat        (q_stat),
    .q_push        (q_push),
    .q_data        (q_data)
  );

  jsu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  jsu_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (q_head),
    .q_stat         (q_stat),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_done_res   (out_done_res),
    .out_error      (out_error),
    .out_last       (out_last)
  );

  `JSU_ASSERT_IMPL(a_pop_nonempty, q_pop, !q_stat.empty, "pop from empty queue")
  `JSU_ASSERT_NEXT(a_empty_holds, q_stat.empty && !q_push, q_stat.empty, "queue filled without push")
  `JSU_ASSERT_IMPL(a_term_last, out_valid && (out_done_res || out_error), out_last, "terminal item not last")
  `JSU_ASSERT_IMPL(a_zero_byte, out_valid && !out_byte_valid, out_byte == 8'd0, "nonzero byte on status item")

endmodule

@@ hdl/jsu_front.sv @@
`timescale 1ns / 1ps
module jsu_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte,
  input  logic             in_buffer_end,
  input  jsu_pkg::q_stat_t q_stat,
  output logic             q_push,
  output jsu_pkg::entry_t  q_data
);

  jsu_pkg::mode_t mode_r, mode_nxt;
  logic [11:0]    hex_r, hex_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic [9:0]     held_r, held_nxt;
  logic           failed_r, failed_nxt;

  logic [4:0]  dig;
  logic [15:0] hex_full;
  logic        take_plain, take_esc, fin, done, fail, accept;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign dig      = jsu_pkg::hex_digit(in_byte);
  assign hex_full = {hex_r, dig[3:0]};

  always_comb begin
    mode_nxt   = mode_r;
    hex_nxt    = hex_r;
    cnt_nxt    = cnt_r;
    held_nxt   = held_r;
    failed_nxt = failed_r;
    take_plain = 1'b0;
    take_esc   = 1'b0;
    fin        = 1'b0;
    done       = 1'b0;
    fail       = 1'b0;
    q_data       = '0;
    q_data.a_lo  = held_r;
    q_data.term  = jsu_pkg::TERM_NONE;

    if (!failed_r) begin
      unique case (mode_r)
        jsu_pkg::M_ESC: take_esc = 1'b1;
        jsu_pkg::M_HEX: begin
          if (!dig[4]) begin
            fail = 1'b1;
          end else if (cnt_r == 2'd3) begin
            fin = 1'b1;
          end else begin
            cnt_nxt = cnt_r + 2'd1;
            hex_nxt = hex_full[11:0];
            fail    = in_buffer_end;
          end
        end
        jsu_pkg::M_HIGH: begin
          if (in_byte == jsu_pkg::CH_BSLASH && !in_buffer_end) begin
            mode_nxt = jsu_pkg::M_HIGH_ESC;
          end else begin
            q_data.has_a = 1'b1;
            take_plain   = 1'b1;
          end
        end
        jsu_pkg::M_HIGH_ESC: begin
          if (in_byte == jsu_pkg::CH_U && !in_buffer_end) begin
            mode_nxt = jsu_pkg::M_LOW_HEX;
            cnt_nxt  = 2'd0;
            hex_nxt  = '0;
          end else begin
            q_data.has_a = 1'b1;
            take_esc     = 1'b1;
          end
        end
        jsu_pkg::M_LOW_HEX: begin
          if (!dig[4]) begin
            q_data.has_a = 1'b1;
            fail         = 1'b1;
          end else if (cnt_r == 2'd3) begin
            if (hex_full[15:10] == jsu_pkg::SURR_LO_TAG) begin
              q_data.b_cp  = jsu_pkg::SUPP_BASE + {1'b0, held_r, hex_full[9:0]};
              q_data.b_len = 3'd4;
              mode_nxt     = jsu_pkg::M_PLAIN;
              cnt_nxt      = 2'd0;
            end else begin
              q_data.has_a = 1'b1;
              fin          = 1'b1;
            end
          end else begin
            cnt_nxt = cnt_r + 2'd1;
            hex_nxt = hex_full[11:0];
            if (in_buffer_end) begin
              q_data.has_a = 1'b1;
              fail         = 1'b1;
            end
          end
        end
        default: take_plain = 1'b1;
      endcase

      if (take_plain) begin
        mode_nxt = jsu_pkg::M_PLAIN;
        if (in_byte == jsu_pkg::CH_QUOTE) begin
          done = 1'b1;
        end else if (in_byte == jsu_pkg::CH_BSLASH && !in_buffer_end) begin
          mode_nxt = jsu_pkg::M_ESC;
        end else begin
          q_data.b_cp  = {13'd0, in_byte};
          q_data.b_len = 3'd1;
        end
      end

      if (take_esc) begin
        mode_nxt = jsu_pkg::M_PLAIN;
        if (in_byte == jsu_pkg::CH_U) begin
          if (in_buffer_end) begin
            fail = 1'b1;
          end else begin
            mode_nxt = jsu_pkg::M_HEX;
            cnt_nxt  = 2'd0;
            hex_nxt  = '0;
          end
        end else begin
          q_data.b_cp  = {13'd0, jsu_pkg::esc_byte(in_byte)};
          q_data.b_len = 3'd1;
        end
      end

      if (fin) begin
        cnt_nxt = 2'd0;
        if (hex_full[15:10] == jsu_pkg::SURR_HI_TAG && !in_buffer_end) begin
          held_nxt = hex_full[9:0];
          mode_nxt = jsu_pkg::M_HIGH;
        end else begin
          q_data.b_cp  = {5'd0, hex_full};
          q_data.b_len = jsu_pkg::utf8_len({5'd0, hex_full});
          mode_nxt     = jsu_pkg::M_PLAIN;
        end
      end
    end

    if (failed_r || (!done && (fail || in_buffer_end))) begin
      q_data.term = jsu_pkg::TERM_ERR;
    end else if (done) begin
      q_data.term = jsu_pkg::TERM_DONE;
    end

    if (!failed_r && fail && !in_buffer_end) begin
      failed_nxt = 1'b1;
    end

    if (done || in_buffer_end) begin
      mode_nxt   = jsu_pkg::M_PLAIN;
      hex_nxt    = '0;
      cnt_nxt    = 2'd0;
      held_nxt   = '0;
      failed_nxt = 1'b0;
    end
  end

  assign q_push = accept && (q_data.has_a || q_data.b_len != 3'd0 ||
                             q_data.term != jsu_pkg::TERM_NONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= jsu_pkg::M_PLAIN;
      hex_r    <= '0;
      cnt_r    <= 2'd0;
      held_r   <= '0;
      failed_r <= 1'b0;
    end else if (accept) begin
      mode_r   <= mode_nxt;
      hex_r    <= hex_nxt;
      cnt_r    <= cnt_nxt;
      held_r   <= held_nxt;
      failed_r <= failed_nxt;
    end
  end

endmodule

@@ hdl/jsu_queue.sv @@
`timescale 1ns / 1ps
module jsu_queue #(
  parameter int DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  jsu_pkg::entry_t  push_data,
  input  logic             pop,
  output jsu_pkg::entry_t  head,
  output jsu_pkg::q_stat_t stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  jsu_pkg::entry_t mem [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign head       = mem[rd_ptr_r];
  assign stat.full  = (cnt_r == FULL_CNT);
  assign stat.empty = (cnt_r == '0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
      end
    end
  end

endmodule

@@ hdl/jsu_back.sv @@
`timescale 1ns / 1ps
module jsu_back (
  input  logic             clk,
  input  logic             rst_n,
  input  jsu_pkg::entry_t  head,
  input  jsu_pkg::q_stat_t q_stat,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             out_byte_valid,
  output logic             out_done_res,
  output logic             out_error,
  output logic             out_last
);

  logic [2:0] k_r, k_nxt;
  logic [3:0] na, nab, total, kx, rel;
  logic       last, load;
  logic [7:0] res_byte;
  logic       res_bv, res_done, res_err;

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_bv_r, out_done_r, out_err_r, out_last_r;

  always_comb begin
    na       = head.has_a ? 4'd3 : 4'd0;
    nab      = na + {1'b0, head.b_len};
    total    = nab + {3'd0, head.term != jsu_pkg::TERM_NONE};
    kx       = {1'b0, k_r};
    rel      = kx - na;
    last     = (kx == total - 4'd1);
    res_byte = 8'd0;
    res_bv   = 1'b0;
    res_done = 1'b0;
    res_err  = 1'b0;
    if (kx < na) begin
      res_byte = jsu_pkg::utf8_byte({5'd0, jsu_pkg::SURR_HI_TAG, head.a_lo}, 3'd3, k_r[1:0]);
      res_bv   = 1'b1;
    end else if (kx < nab) begin
      res_byte = jsu_pkg::utf8_byte(head.b_cp, head.b_len, rel[1:0]);
      res_bv   = 1'b1;
    end else begin
      res_done = (head.term == jsu_pkg::TERM_DONE);
      res_err  = (head.term == jsu_pkg::TERM_ERR);
    end
  end

  assign load  = !q_stat.empty && (!out_valid_r || out_ready);
  assign q_pop = load && last;
  assign k_nxt = !load ? k_r : (last ? 3'd0 : k_r + 3'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      k_r         <= 3'd0;
    end else begin
      k_r <= k_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= res_byte;
      out_bv_r   <= res_bv;
      out_done_r <= res_done;
      out_err_r  <= res_err;
      out_last_r <= last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_byte_valid = out_bv_r;
  assign out_done_res   = out_done_r;
  assign out_error      = out_err_r;
  assign out_last       = out_last_r;

endmodule
